@@ rtl/floppy_disk_controller_registers_macros.svh @@
// Assertion macros shared by the floppy disk controller register block.
// Depends on nothing; included by the files that carry assertions.
`ifndef FLOPPY_DISK_CONTROLLER_REGISTERS_MACROS_SVH
`define FLOPPY_DISK_CONTROLLER_REGISTERS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FDCR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FDCR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("%m: next-cycle check failed");

`endif

@@ rtl/fdcr_pkg.sv @@
// Types and codes of the floppy disk controller register block.
// Used by fdcr_core and by the top level; depends on nothing.
`timescale 1ns / 1ps

package fdcr_pkg;

	localparam int POINTER_W = 22;
	localparam int BASE_W    = 16;

	localparam logic [2:0] REG_CMD_STATUS = 3'd0;
	localparam logic [2:0] REG_TRACK      = 3'd1;
	localparam logic [2:0] REG_SECTOR     = 3'd2;
	localparam logic [2:0] REG_DATA       = 3'd3;
	localparam logic [2:0] REG_SYSTEM     = 3'd4;

	localparam logic [3:0] CMD_RESTORE     = 4'h0;
	localparam logic [3:0] CMD_SEEK        = 4'h1;
	localparam logic [3:0] CMD_READ_ADDR   = 4'hC;
	localparam logic [3:0] CMD_FORCE_INT   = 4'hD;
	localparam logic [3:0] CMD_FORMAT      = 4'hF;

	localparam logic [1:0] IRQ_NONE = 2'd0;
	localparam logic [1:0] IRQ_INT  = 2'd1;
	localparam logic [1:0] IRQ_DRQ  = 2'd2;

	localparam logic [1:0] MEDIA_NONE  = 2'd0;
	localparam logic [1:0] MEDIA_READ  = 2'd1;
	localparam logic [1:0] MEDIA_WRITE = 2'd2;
	localparam logic [1:0] MEDIA_FILL  = 2'd3;

	localparam logic CFG_SECTORS = 1'b0;
	localparam logic CFG_DRIVES  = 1'b1;

	localparam logic [7:0] LAST_CMD_RESET = 8'hD0;
	localparam logic [7:0] FILL_BYTE      = 8'hE5;

	typedef struct packed {
		logic [7:0]           read_data;
		logic [1:0]           request_code;
		logic [1:0]           media_access;
		logic [POINTER_W-1:0] media_address;
		logic [7:0]           media_write_byte;
		logic [POINTER_W-1:0] next_pointer;
	} fdcr_result_t;

endpackage

@@ rtl/fdcr_core.sv @@
// Register state and access decode of the floppy disk controller.
// Depends on fdcr_pkg; instantiated by floppy_disk_controller_registers.
`timescale 1ns / 1ps

module fdcr_core import fdcr_pkg::*; #(
	parameter int SECTOR_BYTES       = 1024,
	parameter int SIDES              = 2,
	parameter int DRIVES             = 4,
	parameter int IMAGE_ADDRESS_BITS = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic         kind,
	input  logic [2:0]   reg_select,
	input  logic [7:0]   write_value,
	input  logic [7:0]   media_byte,
	input  logic         cfg_write,
	input  logic         cfg_index,
	input  logic [5:0]   cfg_data,
	output fdcr_result_t result
);

	localparam int OFS_W   = IMAGE_ADDRESS_BITS;
	localparam int PTR_W   = IMAGE_ADDRESS_BITS + 2;
	localparam int RES_W   = $clog2(SECTOR_BYTES);
	localparam logic [RES_W-1:0] SAT_RES  = RES_W'(65535 % SECTOR_BYTES);
	localparam logic [RES_W-1:0] HDR_RES  = RES_W'(6 % SECTOR_BYTES);
	localparam logic [RES_W-1:0] LAST_RES = RES_W'(SECTOR_BYTES - 1);

	logic [5:0]       spt_q, spt_d;
	logic [3:0]       present_q, present_d;
	logic [7:0]       status_q, status_d, track_q, track_d, sector_q, sector_d;
	logic [7:0]       data_q, data_d, head_q, head_d, wdog_q, wdog_d, last_q, last_d;
	logic             side_q, side_d, outward_q, outward_d, hmode_q, hmode_d;
	logic [1:0]       drive_q, drive_d, irq_q, irq_d;
	logic [15:0]      left_q, left_d;
	logic [RES_W-1:0] res_q, res_d;
	logic [PTR_W-1:0] ptr_q, ptr_d, addr_d;
	logic [2:0]       hidx_q, hidx_d;
	logic [BASE_W-1:0] base_q;
	logic [1:0]       acc_d;
	logic [7:0]       rd_d, wb_d;

	logic              disk_here;
	logic              xfer_side, step_out;
	logic [7:0]        adj;
	logic [BASE_W-1:0] xfer_idx, fill1_idx;
	logic [31:0]       xfer_prod, fill0_prod, fill1_prod, base_prod, count_prod;
	logic [PTR_W-1:0]  xfer_ptr, fill0_ptr, fill1_ptr;
	logic signed [9:0] cnt_s;
	logic [6:0]        count;

	function automatic logic [POINTER_W-1:0] to_out(input logic [PTR_W-1:0] p);
		logic [PTR_W+POINTER_W-1:0] wide;
		wide = (PTR_W+POINTER_W)'(p);
		return wide[POINTER_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return {p[PTR_W-1:OFS_W], p[OFS_W-1:0] + OFS_W'(1)};
	endfunction

	assign disk_here = ({1'b0, drive_q} < 3'(DRIVES)) && present_q[drive_q];

	assign xfer_side  = write_value[1] ? write_value[3] : side_q;
	assign adj        = (sector_q == 8'd0) ? 8'd0 : sector_q - 8'd1;
	assign xfer_idx   = base_q + (xfer_side ? BASE_W'(spt_q) : '0) + BASE_W'(adj);
	assign fill1_idx  = base_q + BASE_W'(spt_q);
	assign xfer_prod  = 32'(xfer_idx) * 32'(SECTOR_BYTES);
	assign fill0_prod = 32'(base_q) * 32'(SECTOR_BYTES);
	assign fill1_prod = 32'(fill1_idx) * 32'(SECTOR_BYTES);
	assign xfer_ptr   = {drive_q, xfer_prod[OFS_W-1:0]};
	assign fill0_ptr  = {drive_q, fill0_prod[OFS_W-1:0]};
	assign fill1_ptr  = (SIDES > 1) ? {drive_q, fill1_prod[OFS_W-1:0]} : fill0_ptr;

	assign cnt_s      = $signed({4'b0, spt_q}) - $signed({2'b0, sector_q}) + 10'sd1;
	assign count      = (cnt_s < 10'sd1) ? 7'd1 : cnt_s[6:0];
	assign count_prod = 32'(count) * 32'(SECTOR_BYTES);

	assign base_prod  = 32'(spt_d) * 32'(track_d) * 32'(SIDES);

	always_comb begin
		spt_d     = spt_q;
		present_d = present_q;
		if (cfg_write && cfg_index == CFG_SECTORS) begin
			spt_d = cfg_data;
		end
		if (cfg_write && cfg_index == CFG_DRIVES) begin
			present_d = cfg_data[3:0];
		end
	end

	always_comb begin
		status_d  = status_q;
		track_d   = track_q;
		sector_d  = sector_q;
		data_d    = data_q;
		head_d    = head_q;
		side_d    = side_q;
		drive_d   = drive_q;
		outward_d = outward_q;
		irq_d     = irq_q;
		left_d    = left_q;
		res_d     = res_q;
		wdog_d    = wdog_q;
		last_d    = last_q;
		ptr_d     = ptr_q;
		hmode_d   = hmode_q;
		hidx_d    = hidx_q;
		acc_d     = MEDIA_NONE;
		addr_d    = '0;
		rd_d      = 8'd0;
		wb_d      = 8'd0;
		step_out  = outward_q;
		if (accept) begin
			if (!kind) begin
				case (reg_select)
					REG_CMD_STATUS: begin
						rd_d = status_q | (disk_here ? 8'h00 : 8'h80);
						if (last_q < 8'h80 || last_q == LAST_CMD_RESET) begin
							status_d = (status_q ^ 8'h02) & 8'hC7;
						end else begin
							status_d = status_q & 8'hC3;
						end
					end
					REG_TRACK:  rd_d = track_q;
					REG_SECTOR: rd_d = sector_q;
					REG_DATA: begin
						if (left_q != 16'd0) begin
							if (hmode_q) begin
								case (hidx_q)
									3'd0:    data_d = head_q;
									3'd1:    data_d = {7'b0, side_q};
									3'd3:    data_d = 8'd3;
									default: data_d = 8'd0;
								endcase
								hidx_d = hidx_q + 3'd1;
							end else begin
								data_d = media_byte;
								acc_d  = MEDIA_READ;
								addr_d = ptr_q;
								ptr_d  = advance(ptr_q);
							end
						end
						rd_d = data_d;
					end
					REG_SYSTEM: begin
						if (wdog_q != 8'd0) begin
							wdog_d = wdog_q - 8'd1;
							if (wdog_d == 8'd0) begin
								left_d   = 16'd0;
								res_d    = '0;
								status_d = (status_q & 8'hFC) | 8'h04;
								irq_d    = IRQ_INT;
							end
						end
						case (irq_d)
							IRQ_INT: rd_d = 8'h80;
							IRQ_DRQ: rd_d = 8'h40;
							default: rd_d = 8'h00;
						endcase
					end
					default: rd_d = 8'hFF;
				endcase
			end else begin
				case (reg_select)
					REG_CMD_STATUS: begin
						irq_d = IRQ_NONE;
						if (write_value[7:4] == CMD_FORCE_INT) begin
							left_d = 16'd0;
							res_d  = '0;
							last_d = LAST_CMD_RESET;
							if (status_q[0]) begin
								status_d = status_q & 8'hFE;
							end else begin
								status_d = ((head_q == 8'd0) ? 8'h04 : 8'h00) | 8'h02;
							end
							if (write_value[3]) begin
								irq_d = IRQ_INT;
							end
						end else if (!status_q[0]) begin
							status_d = 8'h00;
							last_d   = write_value;
							case (write_value[7:4]) inside
								CMD_RESTORE: begin
									head_d   = 8'd0;
									status_d = 8'h06 | (write_value[3] ? 8'h20 : 8'h00);
									track_d  = 8'd0;
									irq_d    = IRQ_INT;
								end
								CMD_SEEK: begin
									left_d   = 16'd0;
									res_d    = '0;
									head_d   = data_q;
									status_d = 8'h02 | ((data_q == 8'd0) ? 8'h04 : 8'h00)
										| (write_value[3] ? 8'h20 : 8'h00);
									track_d  = data_q;
									irq_d    = IRQ_INT;
								end
								[4'h2:4'h7]: begin
									if (write_value[6]) begin
										outward_d = write_value[5];
										step_out  = write_value[5];
									end
									if (step_out) begin
										head_d = (head_q != 8'd0) ? head_q - 8'd1 : head_q;
									end else begin
										head_d = (head_q != 8'hFF) ? head_q + 8'd1 : head_q;
									end
									if (write_value[4]) begin
										track_d = head_d;
									end
									status_d = 8'h02 | ((head_d == 8'd0) ? 8'h04 : 8'h00);
									irq_d    = IRQ_INT;
								end
								[4'h8:4'hB]: begin
									if (!disk_here) begin
										status_d = 8'h10;
										irq_d    = IRQ_INT;
									end else begin
										ptr_d = xfer_ptr;
										if (!write_value[4]) begin
											left_d = 16'(SECTOR_BYTES);
											res_d  = '0;
										end else if (count_prod > 32'd65535) begin
											left_d = 16'hFFFF;
											res_d  = SAT_RES;
										end else begin
											left_d = count_prod[15:0];
											res_d  = '0;
										end
										hmode_d  = 1'b0;
										status_d = 8'h03;
										irq_d    = IRQ_DRQ;
										wdog_d   = 8'hFF;
									end
								end
								CMD_READ_ADDR: begin
									if (!disk_here) begin
										status_d = 8'h10;
										irq_d    = IRQ_INT;
									end else begin
										hmode_d  = 1'b1;
										hidx_d   = 3'd0;
										left_d   = 16'd6;
										res_d    = HDR_RES;
										status_d = 8'h03;
										irq_d    = IRQ_DRQ;
										wdog_d   = 8'hFF;
									end
								end
								CMD_FORMAT: begin
									if (disk_here) begin
										acc_d  = MEDIA_FILL;
										addr_d = fill0_ptr;
										ptr_d  = fill1_ptr;
									end
								end
								default: begin
								end
							endcase
						end
					end
					REG_TRACK: begin
						if (!status_q[0]) begin
							track_d = write_value;
						end
					end
					REG_SECTOR: begin
						if (!status_q[0]) begin
							sector_d = write_value;
						end
					end
					REG_DATA: begin
						if (left_q != 16'd0) begin
							if (hmode_q) begin
								hidx_d = hidx_q + 3'd1;
							end else begin
								acc_d  = MEDIA_WRITE;
								addr_d = ptr_q;
								wb_d   = write_value;
								ptr_d  = advance(ptr_q);
							end
						end
						data_d = write_value;
					end
					REG_SYSTEM: begin
						drive_d = write_value[1:0];
						side_d  = ~write_value[2];
					end
					default: begin
					end
				endcase
			end

			// One transfer byte on the data register counts down the transaction.
			if (reg_select == REG_DATA && left_q != 16'd0) begin
				left_d = left_q - 16'd1;
				res_d  = (res_q == '0) ? LAST_RES : res_q - RES_W'(1);
				if (left_d != 16'd0) begin
					wdog_d = 8'hFF;
					if (res_d == '0) begin
						sector_d = sector_q + 8'd1;
					end
				end else begin
					status_d = status_q & 8'hFC;
					irq_d    = IRQ_INT;
				end
			end
		end
	end

	always_comb begin
		result.read_data        = rd_d;
		result.request_code     = irq_d;
		result.media_access     = acc_d;
		result.media_address    = to_out(addr_d);
		result.media_write_byte = wb_d;
		result.next_pointer     = to_out(ptr_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q     <= 6'd5;
			present_q <= 4'd0;
			status_q  <= 8'd0;
			track_q   <= 8'd0;
			sector_q  <= 8'd0;
			data_q    <= 8'd0;
			head_q    <= 8'd0;
			side_q    <= 1'b0;
			drive_q   <= 2'd0;
			outward_q <= 1'b0;
			irq_q     <= IRQ_NONE;
			left_q    <= 16'd0;
			res_q     <= '0;
			wdog_q    <= 8'd0;
			last_q    <= LAST_CMD_RESET;
			ptr_q     <= '0;
			hmode_q   <= 1'b0;
			hidx_q    <= 3'd0;
			base_q    <= '0;
		end else begin
			spt_q     <= spt_d;
			present_q <= present_d;
			status_q  <= status_d;
			track_q   <= track_d;
			sector_q  <= sector_d;
			data_q    <= data_d;
			head_q    <= head_d;
			side_q    <= side_d;
			drive_q   <= drive_d;
			outward_q <= outward_d;
			irq_q     <= irq_d;
			left_q    <= left_d;
			res_q     <= res_d;
			wdog_q    <= wdog_d;
			last_q    <= last_d;
			ptr_q     <= ptr_d;
			hmode_q   <= hmode_d;
			hidx_q    <= hidx_d;
			base_q    <= base_prod[BASE_W-1:0];
		end
	end

endmodule

@@ rtl/floppy_disk_controller_registers.sv @@
// Top level of the floppy disk controller register block: ports and result buffering.
// Depends on fdcr_pkg, fdcr_core and floppy_disk_controller_registers_macros.svh.
// Every bus transaction is decoded in the cycle it is accepted and its result is held in a
// two-entry output buffer, so the block takes one transaction per clock while in_stall is low;
// in_stall rises only when both buffer entries hold results that out_stall is holding
// back. Image bytes for data reads are supplied on media_byte with the transaction that
// follows the result naming their pointer.
`timescale 1ns / 1ps

`include "floppy_disk_controller_registers_macros.svh"

module floppy_disk_controller_registers import fdcr_pkg::*; #(
	parameter int SECTOR_BYTES       = 1024,
	parameter int SIDES              = 2,
	parameter int DRIVES             = 4,
	parameter int IMAGE_ADDRESS_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [2:0]           reg_select,
	input  logic [7:0]           write_value,
	input  logic [7:0]           media_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           read_data,
	output logic [1:0]           request_code,
	output logic [1:0]           media_access,
	output logic [POINTER_W-1:0] media_address,
	output logic [7:0]           media_write_byte,
	output logic [POINTER_W-1:0] next_pointer,
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [5:0]           cfg_data
);

	logic         accept;
	fdcr_result_t new_result;
	fdcr_result_t out_q, skid_q;
	logic         out_v_q, skid_v_q;

	assign in_stall = skid_v_q;
	assign accept   = in_valid && !skid_v_q;

	fdcr_core #(
		.SECTOR_BYTES       (SECTOR_BYTES),
		.SIDES              (SIDES),
		.DRIVES             (DRIVES),
		.IMAGE_ADDRESS_BITS (IMAGE_ADDRESS_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (kind),
		.reg_select  (reg_select),
		.write_value (write_value),
		.media_byte  (media_byte),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result      (new_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			out_v_q  <= skid_v_q || accept;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			out_q <= skid_v_q ? skid_q : new_result;
		end else if (accept) begin
			skid_q <= new_result;
		end
	end

	assign out_valid        = out_v_q;
	assign read_data        = out_q.read_data;
	assign request_code     = out_q.request_code;
	assign media_access     = out_q.media_access;
	assign media_address    = out_q.media_address;
	assign media_write_byte = out_q.media_write_byte;
	assign next_pointer     = out_q.next_pointer;

	`FDCR_ASSERT_IMPLY(a_skid_needs_out, clk, arst_n, skid_v_q, out_v_q)
	`FDCR_ASSERT_NEXT(a_fill_skid, clk, arst_n, out_v_q && out_stall && accept, skid_v_q)
	`FDCR_ASSERT_NEXT(a_drain_empty, clk, arst_n, out_v_q && !out_stall && !skid_v_q && !accept, !out_valid)
	`FDCR_ASSERT_NEXT(a_skid_moves_up, clk, arst_n, skid_v_q && !out_stall, out_valid && !skid_v_q)

endmodule

@@ tb/sv/floppy_disk_controller_registers_test.sv @@
// Self-checking testbench for floppy_disk_controller_registers: drives bus transactions,
// predicts each result with its own register-level model and compares every output field.
// Depends on fdcr_pkg and the floppy_disk_controller_registers RTL.
`timescale 1ns / 1ps

module floppy_disk_controller_registers_test;
	import fdcr_pkg::*;

	localparam bit         BUS_READ  = 1'b0;
	localparam bit         BUS_WRITE = 1'b1;
	localparam logic [2:0] REG_BAD   = 3'd7;
	localparam logic [3:0] CMD_STEP         = 4'h2;
	localparam logic [3:0] CMD_STEP_IN      = 4'h5;
	localparam logic [3:0] CMD_STEP_OUT     = 4'h7;
	localparam logic [3:0] CMD_READ_SECTOR  = 4'h8;
	localparam logic [3:0] CMD_READ_MULTI   = 4'h9;
	localparam logic [3:0] CMD_WRITE_SECTOR = 4'hA;
	localparam logic [3:0] CMD_WRITE_MULTI  = 4'hB;
	localparam logic [3:0] CMD_READ_TRACK   = 4'hE;
	localparam int         CYCLE_LIMIT      = 200000;

	logic clk, arst_n;
	logic in_valid, in_stall, kind;
	logic [2:0] reg_select;
	logic [7:0] write_value, media_byte;
	logic out_valid, out_stall;
	logic [7:0] read_data, media_write_byte;
	logic [1:0] request_code, media_access;
	logic [POINTER_W-1:0] media_address, next_pointer;
	logic cfg_write, cfg_index;
	logic [5:0] cfg_data;

	floppy_disk_controller_registers u_top (.*);

	// Predicted controller state.
	logic [5:0]  spt;
	logic [3:0]  present;
	logic [7:0]  status_q, track_q, sector_q, data_q, system_q, head_track, last_cmd, watchdog;
	logic        head_side, step_out, hdr_mode;
	logic [1:0]  drive, irq;
	logic [15:0] left;
	logic [21:0] pointer;
	logic [2:0]  hdr_idx;

	fdcr_result_t expected_results[$];
	int fails = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic bit disk_here();
		return present[drive];
	endfunction

	function automatic logic [21:0] locate(logic side, logic [7:0] trk, logic [7:0] sec);
		int unsigned first, adj, ofs;
		first = spt * (trk * 2 + side);
		adj = (sec > 0) ? sec - 1 : 0;
		ofs = (first + adj) * 1024;
		return {drive, ofs[19:0]};
	endfunction

	function automatic logic [21:0] advance(logic [21:0] p);
		return {p[21:20], p[19:0] + 20'd1};
	endfunction

	function automatic void count_byte();
		left = left - 16'd1;
		if (left != 0) begin
			watchdog = 8'd255;
			if (left[9:0] == 0) sector_q = sector_q + 8'd1;
		end else begin
			status_q = status_q & ~8'h03;
			irq = IRQ_INT;
		end
	endfunction

	function automatic void start_transfer(logic [7:0] cmd);
		logic side;
		int c;
		int unsigned n;
		side = cmd[1] ? cmd[3] : head_side;
		if (!disk_here()) begin
			status_q = (status_q & ~8'h18) | 8'h10;
			irq = IRQ_INT;
			return;
		end
		pointer = locate(side, track_q, sector_q);
		c = 1;
		if (cmd[4]) begin
			c = int'(spt) - int'(sector_q) + 1;
			if (c < 1) c = 1;
		end
		n = c * 1024;
		left = (n > 65535) ? 16'hFFFF : n[15:0];
		hdr_mode = 1'b0;
		status_q = status_q | 8'h03;
		irq = IRQ_DRQ;
		watchdog = 8'd255;
	endfunction

	function automatic void run_command(logic [7:0] v, inout fdcr_result_t r);
		logic outward;
		irq = IRQ_NONE;
		if (v[7:4] == CMD_FORCE_INT) begin
			left = 0;
			last_cmd = LAST_CMD_RESET;
			if (status_q[0]) status_q[0] = 1'b0;
			else status_q = ((head_track != 0) ? 8'h00 : 8'h04) | 8'h02;
			if (v[3]) irq = IRQ_INT;
			return;
		end
		if (status_q[0]) return;
		status_q = 0;
		last_cmd = v;
		if (v[7:4] == CMD_RESTORE) begin
			head_track = 0;
			status_q = 8'h06 | (v[3] ? 8'h20 : 8'h00);
			track_q = 0;
			irq = IRQ_INT;
		end else if (v[7:4] == CMD_SEEK) begin
			left = 0;
			head_track = data_q;
			status_q = 8'h02 | ((head_track != 0) ? 8'h00 : 8'h04) | (v[3] ? 8'h20 : 8'h00);
			track_q = head_track;
			irq = IRQ_INT;
		end else if (v[7] == 1'b0) begin
			if (v[6]) step_out = v[5];
			outward = step_out;
			if (outward) begin
				if (head_track != 0) head_track = head_track - 8'd1;
			end else if (head_track != 8'd255) begin
				head_track = head_track + 8'd1;
			end
			if (v[4]) track_q = head_track;
			status_q = 8'h02 | ((head_track != 0) ? 8'h00 : 8'h04);
			irq = IRQ_INT;
		end else if (v[6] == 1'b0) begin
			start_transfer(v);
		end else if (v[7:4] == CMD_READ_ADDR) begin
			if (!disk_here()) begin
				status_q = status_q | 8'h10;
				irq = IRQ_INT;
			end else begin
				hdr_mode = 1'b1;
				hdr_idx = 0;
				left = 6;
				status_q = status_q | 8'h03;
				irq = IRQ_DRQ;
				watchdog = 8'd255;
			end
		end else if (v[7:4] == CMD_FORMAT) begin
			if (disk_here()) begin
				r.media_access = MEDIA_FILL;
				r.media_address = locate(1'b0, track_q, 8'd1);
				pointer = locate(1'b1, track_q, 8'd1);
			end
		end
	endfunction

	function automatic fdcr_result_t predict_access(bit k, logic [2:0] rs, logic [7:0] v,
			logic [7:0] mb);
		fdcr_result_t r;
		int i;
		r = '0;
		if (k == BUS_READ) begin
			case (rs)
				REG_CMD_STATUS: begin
					r.read_data = status_q | (disk_here() ? 8'h00 : 8'h80);
					if (last_cmd < 8'h80 || last_cmd == LAST_CMD_RESET)
						status_q = (status_q ^ 8'h02) & 8'hC7;
					else
						status_q = status_q & 8'hC3;
				end
				REG_TRACK: r.read_data = track_q;
				REG_SECTOR: r.read_data = sector_q;
				REG_DATA: begin
					if (left != 0) begin
						if (hdr_mode) begin
							i = hdr_idx;
							data_q = (i == 0) ? head_track : (i == 1) ? {7'd0, head_side} :
								(i == 3) ? 8'd3 : 8'd0;
							hdr_idx = hdr_idx + 3'd1;
						end else begin
							data_q = mb;
							r.media_access = MEDIA_READ;
							r.media_address = pointer;
							pointer = advance(pointer);
						end
						count_byte();
					end
					r.read_data = data_q;
				end
				REG_SYSTEM: begin
					if (watchdog != 0) begin
						watchdog = watchdog - 8'd1;
						if (watchdog == 0) begin
							left = 0;
							status_q = (status_q & ~8'h03) | 8'h04;
							irq = IRQ_INT;
						end
					end
					r.read_data = (irq == IRQ_INT) ? 8'h80 : (irq == IRQ_DRQ) ? 8'h40 : 8'h00;
				end
				default: r.read_data = 8'hFF;
			endcase
		end else begin
			case (rs)
				REG_CMD_STATUS: run_command(v, r);
				REG_TRACK: if (!status_q[0]) track_q = v;
				REG_SECTOR: if (!status_q[0]) sector_q = v;
				REG_DATA: begin
					if (left != 0) begin
						if (hdr_mode) begin
							hdr_idx = hdr_idx + 3'd1;
						end else begin
							r.media_access = MEDIA_WRITE;
							r.media_address = pointer;
							r.media_write_byte = v;
							pointer = advance(pointer);
						end
						count_byte();
					end
					data_q = v;
				end
				REG_SYSTEM: begin
					drive = v[1:0];
					head_side = ~v[2];
					system_q = v;
				end
				default: ;
			endcase
		end
		r.request_code = irq;
		r.next_pointer = pointer;
		return r;
	endfunction

	always @(posedge clk) begin
		fdcr_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no transaction pending");
				fails++;
			end else begin
				exp_r = expected_results.pop_front();
				if (read_data !== exp_r.read_data) begin
					$error("read_data expected %h got %h", exp_r.read_data, read_data);
					fails++;
				end
				if (request_code !== exp_r.request_code) begin
					$error("request_code expected %0d got %0d", exp_r.request_code, request_code);
					fails++;
				end
				if (media_access !== exp_r.media_access) begin
					$error("media_access expected %0d got %0d", exp_r.media_access, media_access);
					fails++;
				end
				if (media_address !== exp_r.media_address) begin
					$error("media_address expected %h got %h", exp_r.media_address,
						media_address);
					fails++;
				end
				if (media_write_byte !== exp_r.media_write_byte) begin
					$error("media_write_byte expected %h got %h", exp_r.media_write_byte,
						media_write_byte);
					fails++;
				end
				if (next_pointer !== exp_r.next_pointer) begin
					$error("next_pointer expected %h got %h", exp_r.next_pointer, next_pointer);
					fails++;
				end
			end
		end
	end

	task automatic send_access(bit k, logic [2:0] rs, logic [7:0] v,
			logic [7:0] mb = 8'($urandom_range(255)));
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		reg_select <= rs;
		write_value <= v;
		media_byte <= mb;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		expected_results.push_back(predict_access(k, rs, v, mb));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_config(logic idx, logic [5:0] value);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == CFG_SECTORS) spt = value;
		else present = value[3:0];
	endtask

	task automatic send_command(logic [3:0] op, logic [3:0] flags);
		send_access(BUS_WRITE, REG_CMD_STATUS, {op, flags});
	endtask

	task automatic test_directed();
		send_access(BUS_READ, REG_CMD_STATUS, 8'h00);
		send_access(BUS_READ, REG_BAD, 8'h00);
		send_access(BUS_WRITE, 3'd5, 8'hFF);
		send_command(CMD_READ_SECTOR, 4'h0);
		write_config(CFG_DRIVES, 6'd15);
		write_config(CFG_SECTORS, 6'd32);
		send_access(BUS_WRITE, REG_SYSTEM, 8'h00);
		send_access(BUS_WRITE, REG_DATA, 8'hFF);
		send_command(CMD_SEEK, 4'h8);
		send_command(CMD_STEP_IN, 4'h0);
		send_command(CMD_STEP_OUT, 4'h0);
		send_command(CMD_STEP, 4'h0);
		send_command(CMD_RESTORE, 4'h8);
		send_command(CMD_FORCE_INT, 4'h8);
		send_access(BUS_WRITE, REG_SECTOR, 8'd40);
		send_command(CMD_READ_MULTI, 4'h0);
		send_access(BUS_READ, REG_DATA, 8'h00, 8'h00);
		send_access(BUS_READ, REG_DATA, 8'h00, 8'hFF);
		send_command(CMD_READ_TRACK, 4'h0);
		send_access(BUS_WRITE, REG_TRACK, 8'd9);
		send_command(CMD_FORCE_INT, 4'h0);
		send_access(BUS_WRITE, REG_SECTOR, 8'd1);
		send_command(CMD_WRITE_SECTOR, 4'hA);
		send_access(BUS_WRITE, REG_DATA, 8'hFF);
		send_command(CMD_FORCE_INT, 4'h0);
		send_command(CMD_READ_ADDR, 4'h0);
		repeat (7) send_access(BUS_READ, REG_DATA, 8'h00);
		send_command(CMD_FORMAT, 4'h0);
		send_command(CMD_READ_TRACK, 4'h0);
		send_access(BUS_READ, REG_CMD_STATUS, 8'h00);
	endtask

	task automatic test_watchdog();
		send_access(BUS_WRITE, REG_SECTOR, 8'd2);
		send_command(CMD_READ_SECTOR, 4'h0);
		repeat (258) send_access(BUS_READ, REG_SYSTEM, 8'h00);
		send_access(BUS_READ, REG_CMD_STATUS, 8'h00);
	endtask

	task automatic random_session();
		int n;
		logic [3:0] op;
		send_access(BUS_WRITE, REG_SYSTEM, 8'($urandom_range(255)));
		send_access(BUS_WRITE, REG_TRACK, 8'(($urandom_range(3) == 0) ? $urandom_range(255) :
			$urandom_range(4)));
		send_access(BUS_WRITE, REG_SECTOR, 8'(($urandom_range(3) == 0) ? $urandom_range(255) :
			$urandom_range(spt + 1)));
		send_access(BUS_WRITE, REG_DATA, 8'($urandom_range(255)));
		op = 4'($urandom_range(15));
		send_command(op, 4'($urandom_range(15)));
		n = $urandom_range(12);
		repeat (n) begin
			case ($urandom_range(9))
				0: send_access(BUS_READ, REG_CMD_STATUS, 8'h00);
				1: send_access(BUS_READ, REG_SYSTEM, 8'h00);
				2, 3, 4: send_access(BUS_WRITE, REG_DATA, 8'($urandom_range(255)));
				default: send_access(BUS_READ, REG_DATA, 8'($urandom_range(255)));
			endcase
		end
		if ($urandom_range(3) != 0) send_command(CMD_FORCE_INT, 4'($urandom_range(15)));
	endtask

	task automatic test_random(int items);
		repeat (items / 12) begin
			if ($urandom_range(4) == 0)
				send_access(1'($urandom_range(1)), 3'($urandom_range(7)),
					8'($urandom_range(255)));
			else
				random_session();
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 150;
		repeat (30) send_access(1'($urandom_range(1)), 3'($urandom_range(4)),
			8'($urandom_range(255)));
		drain();
		repeat (10) send_access(BUS_READ, 3'($urandom_range(7)), 8'h00);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		reg_select = '0;
		write_value = '0;
		media_byte = '0;
		out_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		spt = 6'd5;
		present = 4'd0;
		status_q = 0; track_q = 0; sector_q = 0; data_q = 0; system_q = 8'h0C;
		head_track = 0; head_side = 0; drive = 0; step_out = 0; irq = IRQ_NONE;
		left = 0; watchdog = 0; last_cmd = LAST_CMD_RESET; pointer = 0;
		hdr_mode = 0; hdr_idx = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 6;
		stall_pct = 58;
		test_directed();
		test_watchdog();
		test_random(24);
		write_config(CFG_SECTORS, 6'd1);
		write_config(CFG_DRIVES, 6'd5);
		send_idle_pct = 58;
		stall_pct = 6;
		test_random(24);
		test_backpressure();
		write_config(CFG_SECTORS, 6'd17);
		write_config(CFG_DRIVES, 6'd10);
		send_idle_pct = 0;
		stall_pct = 0;
		test_random(12);
		write_config(CFG_SECTORS, 6'd32);
		write_config(CFG_DRIVES, 6'd0);
		test_random(12);

		drain();
		repeat (5) @(posedge clk);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
